@@ rtl/core/ipv6tac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tac_pkg
// Shared types and constants of the IPv6 text address checker.
// ----------------------------------------------------------------------------
package ipv6tac_pkg;

    localparam int MAX_CHARS_DEFAULT = 45;

    localparam logic [5:0] CHAR_CNT_SAT    = 6'd63;
    localparam logic [2:0] SEG_LEN_SAT     = 3'd7;
    localparam logic [2:0] SEG_LEN_HEX_MAX = 3'd4;
    localparam logic [2:0] OCT_CNT_SAT     = 3'd7;
    localparam logic [2:0] TAIL_OCTETS     = 3'd4;
    localparam logic [1:0] OCT_DIGITS_MAX  = 2'd3;
    localparam logic [9:0] OCTET_MAX       = 10'd255;
    localparam logic [3:0] GROUP_SAT       = 4'd15;
    localparam logic [3:0] GROUPS_FULL     = 4'd8;
    localparam logic [3:0] GROUPS_SHORT    = 4'd7;

    // Byte classes produced by the front end
    typedef enum logic [2:0] {
        CLS_COLON,
        CLS_DOT,
        CLS_DEC,
        CLS_HEX,
        CLS_OTHER
    } char_cls_t;

    typedef struct packed {
        char_cls_t   cls;
        logic [3:0]  digit;     // decimal value for CLS_DEC
        logic        is_last;
        logic        no_char;
    } item_t;

endpackage
`default_nettype wire

@@ rtl/core/ipv6tac_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tac_front
// Input handshake and byte classification; pushes classified words into the
// queue toward the back end.
// ----------------------------------------------------------------------------
module ipv6tac_front (
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_char_code,
    input  wire logic                 s_is_last,
    input  wire logic                 s_no_char,
    input  wire logic                 q_full,
    output logic                      q_push,
    output ipv6tac_pkg::item_t        q_item
);

    ipv6tac_pkg::char_cls_t cls;

    always_comb begin
        if (s_char_code >= 8'h30 && s_char_code <= 8'h39) begin
            cls = ipv6tac_pkg::CLS_DEC;
        end else if ((s_char_code >= 8'h61 && s_char_code <= 8'h66) ||
                     (s_char_code >= 8'h41 && s_char_code <= 8'h46)) begin
            cls = ipv6tac_pkg::CLS_HEX;
        end else if (s_char_code == 8'h3A) begin
            cls = ipv6tac_pkg::CLS_COLON;
        end else if (s_char_code == 8'h2E) begin
            cls = ipv6tac_pkg::CLS_DOT;
        end else begin
            cls = ipv6tac_pkg::CLS_OTHER;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.cls     = cls;
        q_item.digit   = s_char_code[3:0];  // '0'..'9' are 0x30..0x39
        q_item.is_last = s_is_last;
        q_item.no_char = s_no_char;
    end

endmodule
`default_nettype wire

@@ rtl/core/ipv6tac_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tac_fifo
// Two-entry queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module ipv6tac_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire ipv6tac_pkg::item_t   wr_item,
    output logic                      full,
    input  wire logic                 pop,
    output ipv6tac_pkg::item_t        rd_item,
    output logic                      empty
);

    ipv6tac_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ipv6tac_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tac_back
// Address state tracking per word and result register.
// ----------------------------------------------------------------------------
module ipv6tac_back #(
    parameter int MAX_CHARS = ipv6tac_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_empty,
    input  wire ipv6tac_pkg::item_t   q_item,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_valid_res
);

    typedef struct packed {
        logic [5:0] char_count;
        logic [3:0] group_count;
        logic       dc_seen;
        logic       failed;
        logic [2:0] seg_len;
        logic       seg_has_dot;
        logic       seg_hex_ok;
        logic       tail_ok;
        logic [2:0] octets_done;
        logic [1:0] octet_digits;
        logic [9:0] octet_value;
        logic       octet_lead_zero;
    } addr_state_t;

    localparam addr_state_t STATE_INIT = '{
        char_count: 6'd0, group_count: 4'd0, dc_seen: 1'b0, failed: 1'b0,
        seg_len: 3'd0, seg_has_dot: 1'b0, seg_hex_ok: 1'b1, tail_ok: 1'b1,
        octets_done: 3'd0, octet_digits: 2'd0, octet_value: 10'd0,
        octet_lead_zero: 1'b0
    };

    localparam logic [5:0] CHAR_LIMIT = 6'(MAX_CHARS);

    function automatic addr_state_t close_octet(addr_state_t s);
        addr_state_t r;
        r = s;
        if (s.octet_digits == 2'd0 || s.octet_value > ipv6tac_pkg::OCTET_MAX) begin
            r.tail_ok = 1'b0;
        end
        if (s.octets_done != ipv6tac_pkg::OCT_CNT_SAT) begin
            r.octets_done = s.octets_done + 3'd1;
        end
        r.octet_digits    = 2'd0;
        r.octet_value     = 10'd0;
        r.octet_lead_zero = 1'b0;
        return r;
    endfunction

    function automatic logic [3:0] add_groups(logic [3:0] g, logic [1:0] n);
        logic [4:0] sum;
        sum = {1'b0, g} + {3'b000, n};
        return sum[4] ? ipv6tac_pkg::GROUP_SAT : sum[3:0];
    endfunction

    addr_state_t st_reg, st_next;
    logic        m_valid_reg, m_valid_next;
    logic        res_reg, res_next;
    logic        done, ok, first;
    addr_state_t nx, fin;

    always_comb begin
        nx    = st_reg;
        first = (st_reg.char_count == 6'd0);
        if (!q_item.no_char) begin
            if (st_reg.char_count >= CHAR_LIMIT) begin
                nx.failed = 1'b1;
            end
            if (st_reg.char_count != ipv6tac_pkg::CHAR_CNT_SAT) begin
                nx.char_count = st_reg.char_count + 6'd1;
            end
            if (q_item.cls == ipv6tac_pkg::CLS_COLON) begin
                if (st_reg.seg_len == 3'd0) begin
                    // empty inner segment marks "::"
                    if (!first) begin
                        if (st_reg.dc_seen) begin
                            nx.failed = 1'b1;
                        end
                        nx.dc_seen = 1'b1;
                    end
                end else if (st_reg.seg_has_dot) begin
                    nx.failed = 1'b1;
                end else if (st_reg.seg_len > ipv6tac_pkg::SEG_LEN_HEX_MAX ||
                             !st_reg.seg_hex_ok) begin
                    nx.failed = 1'b1;
                end else begin
                    nx.group_count = add_groups(st_reg.group_count, 2'd1);
                end
                nx.seg_len         = 3'd0;
                nx.seg_has_dot     = 1'b0;
                nx.seg_hex_ok      = 1'b1;
                nx.tail_ok         = 1'b1;
                nx.octets_done     = 3'd0;
                nx.octet_digits    = 2'd0;
                nx.octet_value     = 10'd0;
                nx.octet_lead_zero = 1'b0;
            end else begin
                if (st_reg.seg_len != ipv6tac_pkg::SEG_LEN_SAT) begin
                    nx.seg_len = st_reg.seg_len + 3'd1;
                end
                if (q_item.cls != ipv6tac_pkg::CLS_DEC &&
                    q_item.cls != ipv6tac_pkg::CLS_HEX) begin
                    nx.seg_hex_ok = 1'b0;
                end
                unique case (q_item.cls)
                    ipv6tac_pkg::CLS_DOT: begin
                        nx.seg_has_dot = 1'b1;
                        nx = close_octet(nx);
                    end
                    ipv6tac_pkg::CLS_DEC: begin
                        if (st_reg.octet_digits >= ipv6tac_pkg::OCT_DIGITS_MAX) begin
                            nx.tail_ok = 1'b0;
                        end else begin
                            if (st_reg.octet_digits == 2'd0) begin
                                nx.octet_lead_zero = (q_item.digit == 4'd0);
                            end else if (st_reg.octet_lead_zero) begin
                                nx.tail_ok = 1'b0;
                            end
                            nx.octet_value = 10'({st_reg.octet_value, 3'b000} +
                                                 {st_reg.octet_value, 1'b0} +
                                                 {6'd0, q_item.digit});
                            nx.octet_digits = st_reg.octet_digits + 2'd1;
                        end
                    end
                    default: begin
                        nx.tail_ok = 1'b0;
                    end
                endcase
            end
        end
    end

    // end-of-value evaluation on the updated state
    always_comb begin
        fin = nx;
        ok  = 1'b0;
        if (nx.char_count != 6'd0) begin
            if (nx.seg_len != 3'd0) begin
                if (nx.seg_has_dot) begin
                    fin = close_octet(nx);
                    if (!fin.tail_ok || fin.octets_done != ipv6tac_pkg::TAIL_OCTETS) begin
                        fin.failed = 1'b1;
                    end else begin
                        fin.group_count = add_groups(nx.group_count, 2'd2);
                    end
                end else if (nx.seg_len > ipv6tac_pkg::SEG_LEN_HEX_MAX || !nx.seg_hex_ok) begin
                    fin.failed = 1'b1;
                end else begin
                    fin.group_count = add_groups(nx.group_count, 2'd1);
                end
            end
            ok = !fin.failed && (fin.dc_seen ?
                                 (fin.group_count <= ipv6tac_pkg::GROUPS_SHORT) :
                                 (fin.group_count == ipv6tac_pkg::GROUPS_FULL));
        end
    end

    assign done  = q_item.no_char || q_item.is_last;
    // a word that ends the value needs room in the result register
    assign q_pop = !q_empty && (!done || !m_valid_reg || m_ready);

    always_comb begin
        st_next      = st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;
        if (q_pop) begin
            if (done) begin
                st_next      = STATE_INIT;
                m_valid_next = 1'b1;
                res_next     = ok;
            end else begin
                st_next = nx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= STATE_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_valid_res = res_reg;

endmodule
`default_nettype wire

@@ rtl/core/ipv6_text_address_checker_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_text_address_checker_core
// Streaming validator for textual IPv6 addresses, one character per word.
// ----------------------------------------------------------------------------
// Accepts one character word per clock while the queue has room and returns
// one flag word per value, after the word marked last (or a no_char word,
// which ends the value without a byte). Sustained throughput is one word per
// cycle while the output side does not stall, set by the state update in the
// back end. The last word passes through the queue into the result register,
// which raises m_valid. A two-word queue sits between the classifier and the
// state tracker, and the flag is held in an output register, so input keeps
// flowing while a flag waits to be taken, until the next value's ending word
// reaches the head of the queue and the queue fills behind it.
// Values longer than MAX_CHARS characters are reported invalid.
module ipv6_text_address_checker_core #(
    parameter int MAX_CHARS = ipv6tac_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_is_last,
    input  wire logic       s_no_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_valid_res
);

    ipv6tac_pkg::item_t push_item, pop_item;
    logic q_push, q_pop, q_full, q_empty;

    ipv6tac_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .s_no_char   (s_no_char),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    ipv6tac_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (push_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (pop_item),
        .empty   (q_empty)
    );

    ipv6tac_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res)
    );

endmodule
`default_nettype wire

@@ rtl/core/ipv6tac_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tac_checker
// Port-level assertions for the IPv6 text address checker.
// ----------------------------------------------------------------------------
module ipv6tac_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_valid_res
);

    // a stalled result word holds its flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_valid_res))
        else $error("result word dropped or changed while stalled");

    // reset leaves no result pending
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue is empty after reset, so input is open
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // a full queue blocks only after at least one word went in
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("input ready dropped without an incoming word");

endmodule

bind ipv6_text_address_checker_core ipv6tac_checker u_ipv6tac_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_valid_res (m_valid_res)
);
`default_nettype wire

@@ tb/sv/ipv6_text_address_checker_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_checker_core_test
// Self-checking bench for the streaming IPv6 text address checker.
// ----------------------------------------------------------------------------
// Address strings are split into character words and sent through the input
// channel. A bench-side copy of the checker state predicts each flag word,
// and the monitor compares every flag taken from the output channel against
// the oldest prediction. A handful of directed strings is followed by random
// addresses (mostly well formed, some mutated) and byte noise, run through
// phases with no idling, sender gaps, receiver stalls and both at once.
// ----------------------------------------------------------------------------
module ipv6_text_address_checker_core_test;

    localparam int ADDR_MAX_CHARS  = ipv6tac_pkg::MAX_CHARS_DEFAULT;
    localparam int QUIET_LIMIT     = 4000;
    localparam int WORDS_PER_PHASE = 360;
    localparam int DRAIN_CYCLES    = 8;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       none;
    } char_word_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_code;
    logic       s_is_last;
    logic       s_no_char;
    logic       m_valid;
    logic       m_ready;
    logic       m_valid_res;

    ipv6_text_address_checker_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .s_no_char   (s_no_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res)
    );

    char_word_t char_words_pending[$];
    bit         expected_flags[$];
    logic [7:0] txt[$];
    string      hex_digits = "0123456789abcdefABCDEF";

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  fail_count     = 0;
    int  values_sent    = 0;
    int  words_in       = 0;
    int  flags_out      = 0;
    int  flags_true     = 0;
    int  quiet_cycles   = 0;
    bit  in_taken       = 1'b0;
    bit  flag_new;
    bit  flag_exp;
    char_word_t drv_word;

    // ------------------------------------------------------------------
    // Predicted checker state
    // ------------------------------------------------------------------
    logic [5:0] nc;
    logic [3:0] ng;
    bit         dc_seen;
    bit         addr_bad;
    logic [2:0] seg_len;
    bit         seg_dot;
    bit         seg_hex;
    bit         tail_good;
    logic [2:0] oct_cnt;
    logic [1:0] oct_digs;
    logic [9:0] oct_val;
    bit         oct_zero;

    function void clear_octet();
        oct_digs = '0;
        oct_val  = '0;
        oct_zero = 1'b0;
    endfunction

    function void clear_segment();
        seg_len   = '0;
        seg_dot   = 1'b0;
        seg_hex   = 1'b1;
        tail_good = 1'b1;
        oct_cnt   = '0;
        clear_octet();
    endfunction

    function void clear_address();
        nc       = '0;
        ng       = '0;
        dc_seen  = 1'b0;
        addr_bad = 1'b0;
        clear_segment();
    endfunction

    function void bump_groups(int n);
        if (int'(ng) + n > int'(ipv6tac_pkg::GROUP_SAT)) begin
            ng = ipv6tac_pkg::GROUP_SAT;
        end else begin
            ng = ng + 4'(n);
        end
    endfunction

    function void close_octet();
        if (oct_digs == 0 || oct_val > ipv6tac_pkg::OCTET_MAX) begin
            tail_good = 1'b0;
        end
        if (oct_cnt < ipv6tac_pkg::OCT_CNT_SAT) begin
            oct_cnt = oct_cnt + 3'd1;
        end
        clear_octet();
    endfunction

    function bit is_hex_char(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function void take_char(logic [7:0] c);
        bit first;
        first = (nc == 0);
        if (int'(nc) >= ADDR_MAX_CHARS) begin
            addr_bad = 1'b1;
        end
        if (nc < ipv6tac_pkg::CHAR_CNT_SAT) begin
            nc = nc + 6'd1;
        end
        if (c == CH_COLON) begin
            // empty segment: "::" unless it is the very first byte
            if (seg_len == 0) begin
                if (!first) begin
                    if (dc_seen) begin
                        addr_bad = 1'b1;
                    end
                    dc_seen = 1'b1;
                end
            end else if (seg_dot) begin
                addr_bad = 1'b1;
            end else if (seg_len > ipv6tac_pkg::SEG_LEN_HEX_MAX || !seg_hex) begin
                addr_bad = 1'b1;
            end else begin
                bump_groups(1);
            end
            clear_segment();
        end else begin
            if (seg_len < ipv6tac_pkg::SEG_LEN_SAT) begin
                seg_len = seg_len + 3'd1;
            end
            if (!is_hex_char(c)) begin
                seg_hex = 1'b0;
            end
            if (c == CH_DOT) begin
                seg_dot = 1'b1;
                close_octet();
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                if (oct_digs >= ipv6tac_pkg::OCT_DIGITS_MAX) begin
                    tail_good = 1'b0;
                end else begin
                    if (oct_digs == 0) begin
                        oct_zero = (c == CH_ZERO);
                    end else if (oct_zero) begin
                        tail_good = 1'b0;
                    end
                    oct_val  = 10'(int'(oct_val) * 10 + int'(c - CH_ZERO));
                    oct_digs = oct_digs + 2'd1;
                end
            end else begin
                tail_good = 1'b0;
            end
        end
    endfunction

    function bit address_verdict();
        if (nc == 0) begin
            return 1'b0;
        end
        if (seg_len != 0) begin
            if (seg_dot) begin
                close_octet();
                if (!tail_good || oct_cnt != ipv6tac_pkg::TAIL_OCTETS) begin
                    addr_bad = 1'b1;
                end else begin
                    bump_groups(2);
                end
            end else if (seg_len > ipv6tac_pkg::SEG_LEN_HEX_MAX || !seg_hex) begin
                addr_bad = 1'b1;
            end else begin
                bump_groups(1);
            end
        end
        if (addr_bad) begin
            return 1'b0;
        end
        return dc_seen ? (ng <= ipv6tac_pkg::GROUPS_SHORT) :
                         (ng == ipv6tac_pkg::GROUPS_FULL);
    endfunction

    // Returns 1 when the word ends a value; flag then holds the verdict.
    function bit address_step(input logic [7:0] c, input logic last, input logic none,
                              output bit flag);
        flag = 1'b0;
        if (!none) begin
            take_char(c);
            if (!last) begin
                return 1'b0;
            end
        end
        flag = address_verdict();
        clear_address();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Text building
    // ------------------------------------------------------------------
    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            txt.push_back(s[i]);
        end
    endfunction

    function logic [7:0] pick_hex();
        return hex_digits[$urandom_range(0, 21)];
    endfunction

    function void insert_at(int pos, logic [7:0] c);
        if (pos >= txt.size()) begin
            txt.push_back(c);
        end else begin
            txt.insert(pos, c);
        end
    endfunction

    function void add_hex_group();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) txt.push_back(pick_hex());
    endfunction

    // mode 0 is a clean dotted quad; the others break it in one way
    function void add_tail(bit bad);
        int mode;
        int count;
        int bad_pos;
        mode    = bad ? $urandom_range(1, 7) : 0;
        count   = (mode == 1) ? 3 : (mode == 2) ? 5 : 4;
        bad_pos = $urandom_range(0, count - 1);
        for (int i = 0; i < count; i++) begin
            if (i > 0) begin
                txt.push_back(CH_DOT);
            end
            if (mode >= 4 && i == bad_pos) begin
                case (mode)
                    4: add_text($sformatf("0%0d", $urandom_range(0, 99)));
                    5: add_text($sformatf("%0d", $urandom_range(256, 999)));
                    6: add_text($sformatf("%0d", $urandom_range(1000, 9999)));
                    default: ;  // empty octet
                endcase
            end else begin
                add_text($sformatf("%0d", $urandom_range(0, 255)));
            end
        end
        if (mode == 3) begin
            txt.push_back(CH_DOT);
        end
    endfunction

    function void make_address();
        bit dc;
        bit tail;
        int n;
        int h;
        int p;
        dc   = ($urandom_range(0, 1) == 1);
        n    = dc ? $urandom_range(0, 7) : 8;
        tail = (n >= 2) && ($urandom_range(0, 3) == 0);
        h    = tail ? n - 2 : n;
        p    = $urandom_range(0, h);
        for (int i = 0; i < h; i++) begin
            if (dc && i == p) begin
                add_text("::");
            end else if (i > 0) begin
                txt.push_back(CH_COLON);
            end
            add_hex_group();
        end
        if (dc && p == h) begin
            add_text("::");
        end
        if (tail) begin
            if (h > 0 && !(dc && p == h)) begin
                txt.push_back(CH_COLON);
            end
            add_tail($urandom_range(0, 9) == 0);
        end
    endfunction

    function void mutate();
        int pos;
        pos = $urandom_range(0, txt.size());
        case ($urandom_range(0, 9))
            0: if (txt.size() != 0) txt[pos % txt.size()] = 8'($urandom_range(0, 255));
            1: insert_at(pos, CH_COLON);
            2: insert_at(pos, CH_DOT);
            3: if (txt.size() != 0) txt.delete(pos % txt.size());
            4: insert_at(pos, pick_hex());
            5: begin
                txt.push_back(CH_COLON);
                add_hex_group();
            end
            6: txt.push_front(CH_COLON);
            7: txt.push_back(CH_COLON);
            8: repeat (3) insert_at(pos, pick_hex());
            default: begin
                txt.push_back(CH_COLON);
                add_tail(1'b0);
            end
        endcase
    endfunction

    function void make_noise();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(46, 70) : $urandom_range(1, 20);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: txt.push_back(pick_hex());
                1: txt.push_back(CH_COLON);
                2: txt.push_back(CH_DOT);
                default: txt.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // Turns txt into words; by_none closes the value with a no_char word.
    function void send_text(bit by_none);
        char_word_t w;
        for (int i = 0; i < txt.size(); i++) begin
            w.code = txt[i];
            w.last = (i == txt.size() - 1) && !by_none;
            w.none = 1'b0;
            char_words_pending.push_back(w);
        end
        if (by_none || txt.size() == 0) begin
            // payload of a no_char word is don't-care, so randomize it
            w.code = 8'($urandom_range(0, 255));
            w.last = 1'($urandom_range(0, 1));
            w.none = 1'b1;
            char_words_pending.push_back(w);
        end
        txt.delete();
        values_sent++;
    endfunction

    function void send_str(string s, bit by_none);
        add_text(s);
        send_text(by_none);
    endfunction

    function void make_random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            // empty value
        end else if (r < 75) begin
            make_address();
            if ($urandom_range(0, 2) == 0) begin
                mutate();
            end
            if ($urandom_range(0, 9) == 0) begin
                mutate();
            end
        end else begin
            make_noise();
        end
        send_text($urandom_range(0, 9) == 0);
    endfunction

    // ------------------------------------------------------------------
    // Clock, driver, monitor
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (char_words_pending.size() != 0 &&
                    !(send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)) begin
                    drv_word = char_words_pending.pop_front();
                    s_valid     <= 1'b1;
                    s_char_code <= drv_word.code;
                    s_is_last   <= drv_word.last;
                    s_no_char   <= drv_word.none;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            // input side first: a word taken now cannot yield this cycle's flag
            if (s_valid && s_ready) begin
                words_in++;
                if (address_step(s_char_code, s_is_last, s_no_char, flag_new)) begin
                    expected_flags.push_back(flag_new);
                end
            end
            if (m_valid && m_ready) begin
                flags_out++;
                if (expected_flags.size() == 0) begin
                    $error("valid_res: no flag expected, got %0b", m_valid_res);
                    fail_count++;
                end else begin
                    flag_exp = expected_flags.pop_front();
                    if (flag_exp) begin
                        flags_true++;
                    end
                    if (m_valid_res !== flag_exp) begin
                        $error("valid_res: expected %0b, got %0b", flag_exp, m_valid_res);
                        fail_count++;
                    end
                end
            end
            in_taken <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (char_words_pending.size() != 0 || s_valid || expected_flags.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = '0;
        s_is_last   = 1'b0;
        s_no_char   = 1'b0;
        m_ready     = 1'b0;
        clear_address();

        send_str("", 1'b0);
        send_str("1:2:3:4:5:6:7:8", 1'b0);
        send_str("::", 1'b0);
        send_str("::1", 1'b0);
        send_str("fe80::", 1'b0);
        send_str("ABCD:ef01:2345:6789:abcd:EF01:2345:6789", 1'b0);
        send_str("1::2::3", 1'b0);
        send_str(":::", 1'b0);
        send_str("12345::", 1'b0);
        send_str("::ffff:192.168.0.1", 1'b0);
        send_str("::0.0.0.0", 1'b0);
        send_str("1:2:3:4:5:6:1.2.3.4", 1'b0);
        send_str("::1.2.3.4.", 1'b0);
        send_str("::01.2.3.4", 1'b0);
        send_str("::256.1.1.1", 1'b0);
        send_str("::1.2.3", 1'b0);
        send_str("::1..2.3", 1'b0);
        send_str("1.2.3.4::", 1'b0);
        // longest legal text, then one byte over the limit
        send_str("ffff:ffff:ffff:ffff:ffff:ffff:255.255.255.255", 1'b0);
        send_str(":ffff:ffff:ffff:ffff:ffff:ffff:255.255.255.255", 1'b0);
        send_str("1:2:3:4:5:6:7:8:", 1'b0);
        send_str("1:2:3:4:5:6:7::8", 1'b0);
        send_str("1:2:3:4:5:6:7:8:9", 1'b0);
        send_str("g::", 1'b0);
        send_str("::1", 1'b1);
        // past the byte counter's saturation point
        repeat (35) add_text("1:");
        send_text(1'b0);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            while (char_words_pending.size() < WORDS_PER_PHASE) begin
                make_random_value();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d address values in %0d character words", values_sent, words_in);
        $display("checked %0d flags, %0d of them valid", flags_out, flags_true);
        if (fail_count == 0 && expected_flags.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
